@@ rtl/core/bgms_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package bgms_pkg;

    // Fixed widths of the port fields.
    localparam int ROW_W   = 64;
    localparam int IDX_W   = 6;
    localparam int SIZE_W  = 7;
    localparam int PASS_W  = 4;
    localparam int LIMIT_W = 13;
    localparam int CNT_W   = 13;
    localparam int APB_AW  = 4;
    localparam int APB_DW  = 32;

    localparam int GRID_SIDE_DEF = 64;

    localparam logic [SIZE_W-1:0]  ACTIVE_SIZE_RST  = 7'd64;
    localparam logic [PASS_W-1:0]  MAX_PASSES_RST   = 4'd10;
    localparam logic [LIMIT_W-1:0] CHANGE_LIMIT_RST = 13'd64;

    // Register indexes, taken from paddr[3:2].
    localparam logic [1:0] CFG_ACTIVE_SIZE  = 2'd0;
    localparam logic [1:0] CFG_MAX_PASSES   = 2'd1;
    localparam logic [1:0] CFG_CHANGE_LIMIT = 2'd2;

    // Row position of the row being smoothed relative to the active square.
    typedef struct packed {
        logic row_act;
        logic up_ok;
        logic dn_ok;
    } t_row_ctl;

    // Half of the in-bounds neighborhood size, rounded down.
    function automatic logic [3:0] half_count(input logic [1:0] rows, input logic [1:0] cols);
        logic [3:0] n;
        n = 4'(rows) * 4'(cols);
        return n >> 1;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/binary_grid_majority_smoother_top.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                     Payload
// input     in         start high while busy low     i_row_bits, i_last_row
// result    out        o_strobe, one per row         o_row_bits_res, o_row_index, o_last,
//                                                    o_passes_run, o_converged
// config    in/out     psel/penable/pwrite, pready   paddr, pwdata, prdata
//
// A row without last_row is written straight into the grid memory and the block stays ready.
// A row with last_row starts smoothing: in each pass the shared row unit updates one row per
// cycle from a single read port of the grid memory. After the final pass the grid is sent as
// GRID_SIDE transfers on consecutive cycles.
// Reset is synchronous and active low; it clears control state and restores the registers.
// The receiver cannot stall: each result is presented for exactly one cycle.
module binary_grid_majority_smoother_top #(
    parameter int GRID_SIDE = bgms_pkg::GRID_SIDE_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [bgms_pkg::ROW_W-1:0]    i_row_bits,
    input  logic                          i_last_row,
    output logic                          o_strobe,
    output logic [bgms_pkg::ROW_W-1:0]    o_row_bits_res,
    output logic [bgms_pkg::IDX_W-1:0]    o_row_index,
    output logic                          o_last,
    output logic [bgms_pkg::PASS_W-1:0]   o_passes_run,
    output logic                          o_converged,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bgms_pkg::APB_AW-1:0]   paddr,
    input  logic [bgms_pkg::APB_DW-1:0]   pwdata,
    output logic [bgms_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);

    localparam int AW = $clog2(GRID_SIDE);
    localparam int CW = $clog2(GRID_SIDE + 1);
    localparam int RW = bgms_pkg::ROW_W;
    localparam int IW = bgms_pkg::IDX_W;
    localparam int SW = bgms_pkg::SIZE_W;
    localparam int PW = bgms_pkg::PASS_W;
    localparam int LW = bgms_pkg::LIMIT_W;
    localparam int DW = bgms_pkg::APB_DW;
    localparam logic [CW-1:0] SIDE_MAX  = CW'(GRID_SIDE);
    localparam logic [CW-1:0] LAST_ROW  = CW'(GRID_SIDE - 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(GRID_SIDE - 1);

    // The sequencer either loads rows, runs a pass (issue reads), waits for the
    // change count of the pass, or plays the grid out.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PASS,
        ST_DRAIN,
        ST_OUT,
        ST_TAIL
    } t_state;

    t_state                  r_state;
    logic [AW-1:0]           r_load_cnt;
    logic [CW-1:0]           r_addr;
    logic [PW-1:0]           r_pass;
    logic                    r_conv;

    // Configuration registers.
    logic [SW-1:0]           r_active_size;
    logic [PW-1:0]           r_max_passes;
    logic [LW-1:0]           r_change_limit;

    // Grid memory, one row per entry, with a registered read port.
    logic [GRID_SIDE-1:0]    r_mem [GRID_SIDE];
    logic [GRID_SIDE-1:0]    r_rdata;
    logic                    r_rd_v;
    logic                    r_rd_out;
    logic                    r_rd_pad;
    logic [CW-1:0]           r_rd_addr;

    // Three-row window around the row being smoothed.
    logic [GRID_SIDE-1:0]    r_prev;
    logic [GRID_SIDE-1:0]    r_cur;
    logic [GRID_SIDE-1:0]    r_next;
    logic                    r_win_v;
    logic                    r_win_last;
    logic [AW-1:0]           r_win_c;

    // Changed bits of the row just written, on their way to the counter.
    logic [RW-1:0]           r_diff;
    logic                    r_diff_v;
    logic                    r_diff_last;

    logic [CW-1:0]           w_side;
    logic [PW-1:0]           w_limit;
    logic [PW-1:0]           w_pass_next;
    logic                    w_take;
    logic                    w_issue;
    logic                    w_mem_re;
    logic                    w_we;
    logic [AW-1:0]           w_waddr;
    logic [GRID_SIDE-1:0]    w_wdata;
    logic [GRID_SIDE-1:0]    w_new_row;
    bgms_pkg::t_row_ctl      w_ctl;
    logic [bgms_pkg::CNT_W-1:0] w_total;
    logic                    w_done;

    // An active size beyond the grid is clipped to the grid, and a pass limit of zero
    // still runs one pass.
    assign w_side      = (r_active_size > SW'(GRID_SIDE)) ? SIDE_MAX : CW'(r_active_size);
    assign w_limit     = (r_max_passes == '0) ? PW'(1) : r_max_passes;
    assign w_pass_next = r_pass + PW'(1);

    assign busy    = (r_state != ST_IDLE);
    assign w_take  = start && (r_state == ST_IDLE);
    assign pready  = 1'b1;

    // ------------------------------------------------------------------
    // Configuration port.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_size  <= bgms_pkg::ACTIVE_SIZE_RST;
            r_max_passes   <= bgms_pkg::MAX_PASSES_RST;
            r_change_limit <= bgms_pkg::CHANGE_LIMIT_RST;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                bgms_pkg::CFG_ACTIVE_SIZE:  r_active_size  <= pwdata[SW-1:0];
                bgms_pkg::CFG_MAX_PASSES:   r_max_passes   <= pwdata[PW-1:0];
                bgms_pkg::CFG_CHANGE_LIMIT: r_change_limit <= pwdata[LW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (paddr[3:2])
            bgms_pkg::CFG_ACTIVE_SIZE:  prdata = DW'(r_active_size);
            bgms_pkg::CFG_MAX_PASSES:   prdata = DW'(r_max_passes);
            bgms_pkg::CFG_CHANGE_LIMIT: prdata = DW'(r_change_limit);
            default:                    prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer. During a pass the read counter runs one step past the last
    // row; that extra step pushes a zero row into the window so that the last
    // row gets smoothed. The pass ends when the counter reports the total
    // number of changed cells.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_load_cnt <= '0;
            r_addr     <= '0;
            r_pass     <= '0;
            r_conv     <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (start) begin
                        if (i_last_row) begin
                            r_load_cnt <= '0;
                            r_addr     <= '0;
                            r_pass     <= '0;
                            r_conv     <= 1'b0;
                            r_state    <= ST_PASS;
                        end else begin
                            r_load_cnt <= (r_load_cnt == LAST_ADDR) ? '0
                                                                    : r_load_cnt + AW'(1);
                        end
                    end
                end
                ST_PASS: begin
                    r_addr <= r_addr + CW'(1);
                    if (r_addr == SIDE_MAX) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (w_done) begin
                        r_pass <= w_pass_next;
                        r_addr <= '0;
                        if (w_total < r_change_limit) begin
                            r_conv  <= 1'b1;
                            r_state <= ST_OUT;
                        end else if (w_pass_next >= w_limit) begin
                            r_state <= ST_OUT;
                        end else begin
                            r_state <= ST_PASS;
                        end
                    end
                end
                ST_OUT: begin
                    r_addr <= r_addr + CW'(1);
                    if (r_addr == LAST_ROW) begin
                        r_state <= ST_TAIL;
                    end
                end
                ST_TAIL: begin
                    r_state <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Memory ports. The write port takes loaded rows while idle and smoothed
    // rows during a pass; the read port serves passes and the playout.
    // ------------------------------------------------------------------
    assign w_issue  = (r_state == ST_PASS) || (r_state == ST_OUT);
    assign w_mem_re = w_issue && (r_addr != SIDE_MAX);
    assign w_we     = w_take || r_win_v;
    assign w_waddr  = r_win_v ? r_win_c : r_load_cnt;
    assign w_wdata  = r_win_v ? w_new_row : i_row_bits[GRID_SIDE-1:0];

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_mem_re) begin
            r_rdata <= r_mem[r_addr[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_v <= 1'b0;
        end else begin
            r_rd_v <= w_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_out  <= (r_state == ST_OUT);
        r_rd_pad  <= (r_addr == SIDE_MAX);
        r_rd_addr <= r_addr;
    end

    // ------------------------------------------------------------------
    // Window. Old rows are held here before their smoothed values overwrite
    // them in memory, so one copy of the grid is enough. The first read of a
    // pass clears the rows above the top of the grid.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (r_rd_v && !r_rd_out) begin
            r_prev  <= (r_rd_addr == '0) ? '0 : r_cur;
            r_cur   <= (r_rd_addr == '0) ? '0 : r_next;
            r_next  <= r_rd_pad ? '0 : r_rdata;
            r_win_c <= AW'(r_rd_addr - CW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_v    <= 1'b0;
            r_win_last <= 1'b0;
        end else begin
            r_win_v    <= r_rd_v && !r_rd_out && (r_rd_addr != '0);
            r_win_last <= r_rd_v && !r_rd_out && r_rd_pad;
        end
    end

    assign w_ctl.row_act = CW'(r_win_c) < w_side;
    assign w_ctl.up_ok   = (r_win_c != '0);
    assign w_ctl.dn_ok   = (CW'(r_win_c) + CW'(1)) < w_side;

    bgms_row_unit #(
        .GRID_SIDE (GRID_SIDE)
    ) u_row_unit (
        .i_prev (r_prev),
        .i_cur  (r_cur),
        .i_next (r_next),
        .i_ctl  (w_ctl),
        .i_side (w_side),
        .o_row  (w_new_row)
    );

    // ------------------------------------------------------------------
    // Change count of the pass.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        r_diff <= RW'(r_cur ^ w_new_row);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_diff_v    <= 1'b0;
            r_diff_last <= 1'b0;
        end else begin
            r_diff_v    <= r_win_v;
            r_diff_last <= r_win_v && r_win_last;
        end
    end

    bgms_pop_acc u_pop_acc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_diff_v),
        .i_last  (r_diff_last),
        .i_diff  (r_diff),
        .o_total (w_total),
        .o_done  (w_done)
    );

    // ------------------------------------------------------------------
    // Result transfers come straight from the registered memory read.
    // ------------------------------------------------------------------
    assign o_strobe       = r_rd_v && r_rd_out;
    assign o_row_bits_res = RW'(r_rdata);
    assign o_row_index    = IW'(r_rd_addr);
    assign o_last         = o_strobe && (r_rd_addr == LAST_ROW);
    assign o_passes_run   = r_pass;
    assign o_converged    = r_conv;

`ifndef NO_ASSERTIONS
    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> busy)
        else $error("result transfer while the block is idle");

    a_start_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_last_row) |=> (busy && !o_strobe))
        else $error("final row did not start smoothing");

    a_window_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_win_v |-> (r_state == ST_PASS || r_state == ST_DRAIN))
        else $error("smoothed row written outside a pass");

    a_pass_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_passes_run != '0 && o_passes_run <= w_limit))
        else $error("pass count out of range on a result");
`endif

endmodule

`default_nettype wire

@@ rtl/core/bgms_row_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bgms_row_unit #(
    parameter int GRID_SIDE = bgms_pkg::GRID_SIDE_DEF,
    localparam int CW = $clog2(GRID_SIDE + 1)
) (
    input  logic [GRID_SIDE-1:0] i_prev,
    input  logic [GRID_SIDE-1:0] i_cur,
    input  logic [GRID_SIDE-1:0] i_next,
    input  bgms_pkg::t_row_ctl   i_ctl,
    input  logic [CW-1:0]        i_side,
    output logic [GRID_SIDE-1:0] o_row
);

    logic [GRID_SIDE-1:0] w_cm;
    logic [GRID_SIDE-1:0] w_p;
    logic [GRID_SIDE-1:0] w_c;
    logic [GRID_SIDE-1:0] w_n;
    logic [1:0]           w_cs [GRID_SIDE+2];

    always_comb begin
        for (int j = 0; j < GRID_SIDE; j++) begin
            w_cm[j] = CW'(j) < i_side;
        end
        w_p = i_ctl.up_ok ? (i_prev & w_cm) : '0;
        w_c = i_cur & w_cm;
        w_n = i_ctl.dn_ok ? (i_next & w_cm) : '0;
    end

    // Column sums, with a zero column on each side of the grid.
    always_comb begin
        w_cs[0]           = '0;
        w_cs[GRID_SIDE+1] = '0;
        for (int j = 0; j < GRID_SIDE; j++) begin
            w_cs[j+1] = 2'(w_p[j]) + 2'(w_c[j]) + 2'(w_n[j]);
        end
    end

    always_comb begin
        logic [3:0] f;
        logic [1:0] rows;
        logic [1:0] cols;
        rows = 2'd1 + 2'(i_ctl.up_ok) + 2'(i_ctl.dn_ok);
        for (int j = 0; j < GRID_SIDE; j++) begin
            f        = 4'(w_cs[j]) + 4'(w_cs[j+1]) + 4'(w_cs[j+2]);
            cols     = 2'd1 + 2'(j > 0) + 2'(CW'(j + 1) < i_side);
            o_row[j] = i_ctl.row_act & w_cm[j] & (f > bgms_pkg::half_count(rows, cols));
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/bgms_pop_acc.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bgms_pop_acc (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic                          i_last,
    input  logic [bgms_pkg::ROW_W-1:0]    i_diff,
    output logic [bgms_pkg::CNT_W-1:0]    o_total,
    output logic                          o_done
);

    localparam int NB = bgms_pkg::ROW_W / 8;

    logic [3:0]                   r_part [NB];
    logic                         r_p_v;
    logic                         r_p_last;
    logic [bgms_pkg::CNT_W-1:0]   r_total;
    logic                         r_done;
    logic                         r_first;
    logic [3:0]                   w_part [NB];
    logic [6:0]                   w_sum;

    always_comb begin
        for (int k = 0; k < NB; k++) begin
            w_part[k] = '0;
            for (int b = 0; b < 8; b++) begin
                w_part[k] = w_part[k] + 4'(i_diff[8*k+b]);
            end
        end
    end

    always_comb begin
        w_sum = '0;
        for (int k = 0; k < NB; k++) begin
            w_sum = w_sum + 7'(r_part[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_part <= w_part;
        end
        if (r_p_v) begin
            r_total <= (r_first ? '0 : r_total) + bgms_pkg::CNT_W'(w_sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_v    <= 1'b0;
            r_p_last <= 1'b0;
            r_done   <= 1'b0;
            r_first  <= 1'b1;
        end else begin
            r_p_v    <= i_valid;
            r_p_last <= i_valid & i_last;
            r_done   <= r_p_v & r_p_last;
            if (r_p_v) begin
                r_first <= r_p_last;
            end
        end
    end

    assign o_total = r_total;
    assign o_done  = r_done;

endmodule

`default_nettype wire

@@ verif/tb.sv @@
`timescale 1ns / 1ps

// Testbench for the binary grid majority smoother.
//
// Rows are sent through the start/busy handshake. Every accepted row is passed to
// a scoreboard that keeps its own copy of the grid and the three control registers.
// When a row marked last_row is accepted, the scoreboard runs the smoothing passes
// itself and queues the GRID_SIDE rows the block should send back. Each result
// transfer is compared field by field with the oldest queued row.
//
// The first grid loads every row, so that no row is ever read before it is written.
// Later grids may be partial loads, because every row holds a known value by then.
module tb;

    localparam int ROW_W   = bgms_pkg::ROW_W;
    localparam int IDX_W   = bgms_pkg::IDX_W;
    localparam int SIZE_W  = bgms_pkg::SIZE_W;
    localparam int PASS_W  = bgms_pkg::PASS_W;
    localparam int LIMIT_W = bgms_pkg::LIMIT_W;
    localparam int APB_AW  = bgms_pkg::APB_AW;
    localparam int APB_DW  = bgms_pkg::APB_DW;

    localparam int SIDE         = bgms_pkg::GRID_SIDE_DEF;
    localparam int CYCLE_LIMIT  = 5_000_000;
    // Rows to send in all, the directed part included.
    localparam int ITEM_COUNT   = 500;
    // A row without last_row is stored without making the block busy, so a short pause
    // is enough before the registers may be written.
    localparam int QUIET_CYCLES = 8;
    localparam int TAIL_CYCLES  = 32;

    // One smoothed row as the block sends it.
    typedef struct {
        logic [ROW_W-1:0]  bits;
        logic [IDX_W-1:0]  idx;
        logic              last;
        logic [PASS_W-1:0] passes;
        logic              conv;
    } t_row_result;

    // Holds the grid, the register copies and the queue of rows still to come back.
    class grid_scoreboard;
        logic [ROW_W-1:0]   grid [SIDE];
        int unsigned        load_cnt;
        logic [SIZE_W-1:0]  act_size;
        logic [PASS_W-1:0]  pass_cap;
        logic [LIMIT_W-1:0] change_floor;
        t_row_result        expected_rows [$];
        int unsigned        mismatches;

        function new();
            foreach (grid[i]) grid[i] = '0;
            load_cnt     = 0;
            act_size     = bgms_pkg::ACTIVE_SIZE_RST;
            pass_cap     = bgms_pkg::MAX_PASSES_RST;
            change_floor = bgms_pkg::CHANGE_LIMIT_RST;
            mismatches   = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [APB_DW-1:0] value);
            case (idx)
                bgms_pkg::CFG_ACTIVE_SIZE:  act_size     = value[SIZE_W-1:0];
                bgms_pkg::CFG_MAX_PASSES:   pass_cap     = value[PASS_W-1:0];
                bgms_pkg::CFG_CHANGE_LIMIT: change_floor = value[LIMIT_W-1:0];
                default: ;
            endcase
        endfunction

        // One majority pass over the active square; returns the changed cell count.
        function int unsigned smooth_once(int side);
            logic [ROW_W-1:0] next_rows [SIDE];
            int unsigned      changed;
            int               n;
            int               f;
            int               r;
            int               c;
            changed = 0;
            for (int i = 0; i < SIDE; i++) begin
                next_rows[i] = '0;
                if (i < side) begin
                    for (int j = 0; j < side; j++) begin
                        n = 0;
                        f = 0;
                        for (int dr = -1; dr <= 1; dr++) begin
                            for (int dc = -1; dc <= 1; dc++) begin
                                r = i + dr;
                                c = j + dc;
                                if (r >= 0 && r < side && c >= 0 && c < side) begin
                                    n++;
                                    if (grid[r][c]) f++;
                                end
                            end
                        end
                        if (f > n / 2) next_rows[i][j] = 1'b1;
                    end
                end
            end
            for (int i = 0; i < SIDE; i++) begin
                changed += $countones(grid[i] ^ next_rows[i]);
                grid[i] = next_rows[i];
            end
            return changed;
        endfunction

        // Called for every accepted row.
        function void take_row(logic [ROW_W-1:0] bits, logic last_row);
            int          side;
            int          cap;
            int          done;
            bit          conv;
            t_row_result res;
            grid[load_cnt] = bits;
            if (!last_row) begin
                load_cnt = (load_cnt + 1) % SIDE;
                return;
            end
            load_cnt = 0;
            // Sizes above the grid saturate; a pass limit of zero still runs one pass.
            side = (act_size > SIDE) ? SIDE : int'(act_size);
            cap  = (pass_cap == 0) ? 1 : int'(pass_cap);
            done = 0;
            conv = 1'b0;
            while (done < cap && !conv) begin
                if (smooth_once(side) < change_floor) conv = 1'b1;
                done++;
            end
            for (int i = 0; i < SIDE; i++) begin
                res.bits   = grid[i];
                res.idx    = IDX_W'(i);
                res.last   = (i == SIDE - 1);
                res.passes = PASS_W'(done);
                res.conv   = conv;
                expected_rows.push_back(res);
            end
        endfunction

        task report_error(string what);
            mismatches++;
            $display("[%0t] row check error: %s", $time, what);
        endtask

        task match_row(t_row_result got);
            t_row_result want;
            if (expected_rows.size() == 0) begin
                report_error($sformatf("row %0d arrived with nothing outstanding", got.idx));
                return;
            end
            want = expected_rows.pop_front();
            if (got.bits !== want.bits)
                report_error($sformatf("row %0d bits %h, expected %h",
                                       want.idx, got.bits, want.bits));
            if (got.idx !== want.idx)
                report_error($sformatf("row index %0d, expected %0d", got.idx, want.idx));
            if (got.last !== want.last)
                report_error($sformatf("row %0d last %b, expected %b",
                                       want.idx, got.last, want.last));
            if (got.passes !== want.passes)
                report_error($sformatf("row %0d passes %0d, expected %0d",
                                       want.idx, got.passes, want.passes));
            if (got.conv !== want.conv)
                report_error($sformatf("row %0d converged %b, expected %b",
                                       want.idx, got.conv, want.conv));
        endtask
    endclass

    // Every input starts at a known value.
    logic                i_clk          = 1'b0;
    logic                i_rst_n        = 1'b0;
    logic                start          = 1'b0;
    logic [ROW_W-1:0]    i_row_bits     = '0;
    logic                i_last_row     = 1'b0;
    logic                psel           = 1'b0;
    logic                penable        = 1'b0;
    logic                pwrite         = 1'b0;
    logic [APB_AW-1:0]   paddr          = '0;
    logic [APB_DW-1:0]   pwdata         = '0;
    logic                busy;
    logic                o_strobe;
    logic [ROW_W-1:0]    o_row_bits_res;
    logic [IDX_W-1:0]    o_row_index;
    logic                o_last;
    logic [PASS_W-1:0]   o_passes_run;
    logic                o_converged;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    grid_scoreboard      sb;
    int unsigned         rows_sent   = 0;
    int unsigned         cycle_count = 0;
    int                  burst_left  = 0;
    bit                  steady      = 1'b1;

    binary_grid_majority_smoother_top #(
        .GRID_SIDE(SIDE)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_row_bits     (i_row_bits),
        .i_last_row     (i_last_row),
        .o_strobe       (o_strobe),
        .o_row_bits_res (o_row_bits_res),
        .o_row_index    (o_row_index),
        .o_last         (o_last),
        .o_passes_run   (o_passes_run),
        .o_converged    (o_converged),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #5 i_clk = ~i_clk;

    // Results cannot be held off, so every cycle with the strobe high is one transfer.
    // Sampling at the edge sees the values that were present during the cycle.
    always @(posedge i_clk) begin : watch_results
        t_row_result got;
        if (i_rst_n && o_strobe) begin
            got = '{o_row_bits_res, o_row_index, o_last, o_passes_run, o_converged};
            sb.match_row(got);
        end
    end

    // Keeps start high until a rising edge finds busy low; that edge is the transfer.
    // The caller either sends the next row or lowers start, never both in one step.
    task automatic send_row(input logic [ROW_W-1:0] bits, input logic last_row);
        start      <= 1'b1;
        i_row_bits <= bits;
        i_last_row <= last_row;
        do @(posedge i_clk); while (busy !== 1'b0);
        sb.take_row(bits, last_row);
        rows_sent++;
    endtask

    task automatic hold_off(input int cycles);
        if (cycles > 0) begin
            start <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    // Sender gaps: bursts of random length separated by random pauses, unless the
    // current phase runs without any idling.
    task automatic sender_gap();
        if (steady) return;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            hold_off($urandom_range(1, 8));
            burst_left = $urandom_range(0, 24);
        end
    endtask

    // Waits until every queued row has come back, then lets the block settle.
    task automatic drain();
        start <= 1'b0;
        while (sb.expected_rows.size() != 0) @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    // Setup phase, access phase, then an idle phase so that back-to-back writes
    // never touch psel twice in the same step.
    task automatic write_reg(input logic [1:0] idx, input logic [APB_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        sb.write_reg(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic program_regs(input int size, input int passes, input int limit);
        write_reg(bgms_pkg::CFG_ACTIVE_SIZE, APB_DW'(size));
        write_reg(bgms_pkg::CFG_MAX_PASSES, APB_DW'(passes));
        write_reg(bgms_pkg::CFG_CHANGE_LIMIT, APB_DW'(limit));
    endtask

    // Row contents range from empty through sparse noise and solid runs to full.
    function automatic logic [ROW_W-1:0] pick_row();
        logic [ROW_W-1:0] a;
        logic [ROW_W-1:0] b;
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return a & b;
            3:       return a | b;
            4:       return ({ROW_W{1'b1}} << $urandom_range(0, 63)) &
                            ({ROW_W{1'b1}} >> $urandom_range(0, 63));
            default: return a;
        endcase
    endfunction

    task automatic send_grid(input int rows);
        for (int k = 0; k < rows; k++) begin
            send_row(pick_row(), k == rows - 1);
            sender_gap();
        end
    endtask

    function automatic int pick_size();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return 1;
            2:       return SIDE;
            3:       return 127;
            4:       return $urandom_range(SIDE + 1, 127);
            5:       return $urandom_range(17, SIDE - 1);
            default: return $urandom_range(2, 16);
        endcase
    endfunction

    function automatic int pick_limit();
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return 8191;
            2:       return 4096;
            3:       return $urandom_range(0, 8191);
            default: return $urandom_range(1, 40);
        endcase
    endfunction

    // Run limit. Even if every row closed a grid with fifteen full passes, the whole run
    // would stay well below this bound.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        logic [ROW_W-1:0] pattern;
        int               n_grids;
        sb = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. The first grid writes every row under the reset register values, back
        // to back, with all-ones, empty, striped, single-bit, half-set and random rows.
        for (int i = 0; i < SIDE; i++) begin
            case (i % 8)
                0:       pattern = '1;
                1:       pattern = '0;
                2:       pattern = {(ROW_W/2){2'b01}};
                3:       pattern = {(ROW_W/2){2'b10}};
                4:       pattern = ROW_W'(1);
                5:       pattern = {1'b1, {(ROW_W-1){1'b0}}};
                6:       pattern = {{(ROW_W/2){1'b1}}, {(ROW_W/2){1'b0}}};
                default: pattern = {$urandom, $urandom};
            endcase
            send_row(pattern, i == SIDE - 1);
        end

        // An empty active square clears the whole grid.
        drain();
        program_regs(0, 3, 64);
        send_row({$urandom, $urandom}, 1'b1);

        // Size beyond the grid saturates; a pass limit of zero runs a single pass.
        drain();
        program_regs(127, 0, 8191);
        send_row('1, 1'b1);

        // A one-cell square with a zero change limit never converges: fifteen passes.
        drain();
        program_regs(1, 15, 0);
        send_row('1, 1'b0);
        send_row('0, 1'b0);
        send_row({ROW_W{1'b1}}, 1'b1);

        // Full square with two checkerboard rows, so many cells flip in the first pass.
        drain();
        program_regs(SIDE, 15, 4096);
        send_row({(ROW_W/2){2'b01}}, 1'b0);
        send_row({(ROW_W/2){2'b10}}, 1'b1);

        drain();
        program_regs(2, 1, 1);
        send_row({$urandom, $urandom}, 1'b1);

        // Random part: each phase programs new registers while the block is idle and
        // then sends a few grids. Most grids are short partial loads; some run past
        // GRID_SIDE rows so that the load counter wraps before last_row arrives.
        pattern = '0;
        while (rows_sent < ITEM_COUNT) begin
            drain();
            program_regs(pick_size(), $urandom_range(0, 15), pick_limit());
            steady     = ($urandom_range(0, 3) == 0);
            burst_left = $urandom_range(0, 24);
            n_grids    = $urandom_range(1, 3);
            for (int g = 0; g < n_grids; g++) begin
                if ($urandom_range(0, 9) == 0) send_grid($urandom_range(SIDE - 4, SIDE + 6));
                else send_grid($urandom_range(1, 12));
                // Now and then the sender waits for every outstanding row first.
                if ($urandom_range(0, 3) == 0) drain();
            end
        end

        // All rows are in; wait for the last grid and a little beyond it.
        start <= 1'b0;
        while (sb.expected_rows.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (sb.mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/bgms_pkg.sv
rtl/core/bgms_row_unit.sv
rtl/core/bgms_pop_acc.sv
rtl/core/binary_grid_majority_smoother_top.sv
verif/tb.sv
